@@ sv/brs_pkg.sv @@
// Batch recipe sequencer package: state, command and phase codes,
// item and result types shared by the channel interfaces and the modules.
// No dependencies.
`default_nettype none

package brs_pkg;

  localparam int unsigned PresW    = 14;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned StateW   = 4;
  localparam int unsigned StepW    = 3;

  localparam logic [PresW-1:0] LowLimitRst  = 14'd900;
  localparam logic [PresW-1:0] HighLimitRst = 14'd1000;

  localparam logic [StepW-1:0] StepFirst = 3'd1;
  localparam logic [StepW-1:0] StepLast  = 3'd6;
  localparam logic [StepW-1:0] StepLoop  = 3'd5;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOW_LIMIT  = 1'd0,
    CFG_HIGH_LIMIT = 1'd1
  } cfg_idx_e;

  typedef enum logic [StateW-1:0] {
    ST_IDLE      = 4'd0,
    ST_EXEC      = 4'd1,
    ST_HOLDING   = 4'd2,
    ST_HELD      = 4'd3,
    ST_RESUMING  = 4'd4,
    ST_STOPPING  = 4'd5,
    ST_STOPPED   = 4'd6,
    ST_RESETTING = 4'd7,
    ST_COMPLETE  = 4'd8
  } state_e;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_START  = 3'd1,
    ACT_HOLD   = 3'd2,
    ACT_STOP   = 3'd3,
    ACT_RESUME = 3'd4,
    ACT_RESET  = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_EXEC     = 3'd1,
    PH_HELD     = 3'd2,
    PH_STOPPED  = 3'd3,
    PH_COMPLETE = 3'd4,
    PH_OTHER    = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_HOLD   = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_RESUME = 3'd3,
    CMD_RESET  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    REQ_NONE     = 2'd0,
    REQ_INJECT   = 2'd1,
    REQ_DISSOLVE = 2'd2
  } req_e;

  typedef struct packed {
    logic [2:0]       action;
    logic [2:0]       inject_phase;
    logic [2:0]       dissolve_phase;
    logic [PresW-1:0] pressure;
  } item_t;

  typedef struct packed {
    logic [StateW-1:0] proc_state;
    logic [StepW-1:0]  recipe_step;
    logic [1:0]        phase_request;
    logic [1:0]        inject_amount;
    logic [2:0]        unit_command;
  } result_t;

  function automatic logic phase_settled(logic [2:0] p);
    return (p == PH_IDLE) || (p == PH_STOPPED) || (p == PH_COMPLETE);
  endfunction

endpackage

`default_nettype wire

@@ sv/brs_in_if.sv @@
// Command/tick input channel: valid, ready and the item fields.
// Depends on brs_pkg.
`default_nettype none

interface brs_in_if
  import brs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [2:0]       action;
  logic [2:0]       inject_phase;
  logic [2:0]       dissolve_phase;
  logic [PresW-1:0] pressure;

  modport source (output valid, action, inject_phase, dissolve_phase, pressure,
                  input ready);
  modport sink   (input valid, action, inject_phase, dissolve_phase, pressure,
                  output ready);
endinterface

`default_nettype wire

@@ sv/brs_out_if.sv @@
// Result output channel: valid, ready and the result fields.
// Depends on brs_pkg.
`default_nettype none

interface brs_out_if
  import brs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [StateW-1:0] proc_state;
  logic [StepW-1:0]  recipe_step;
  logic [1:0]        phase_request;
  logic [1:0]        inject_amount;
  logic [2:0]        unit_command;

  modport source (output valid, proc_state, recipe_step, phase_request,
                  inject_amount, unit_command, input ready);
  modport sink   (input valid, proc_state, recipe_step, phase_request,
                  inject_amount, unit_command, output ready);
endinterface

`default_nettype wire

@@ sv/batch_recipe_sequencer_top.sv @@
// Batch recipe sequencer top level: input register, state machine,
// limit registers and result register. Depends on brs_pkg, brs_in_if,
// brs_out_if, brs_cfg and brs_fsm.
// Path: input register, then the result register once it is free.
// Throughput: one item per cycle while results are not stalled.
// Reset: idle, step one, limits 900 and 1000, both registers empty.
`default_nettype none

module batch_recipe_sequencer_top
  import brs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  brs_in_if.sink                  in_chan,
  brs_out_if.source               out_chan,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [PresW-1:0]   cfg_data_i
);

  logic             in_valid_q;
  item_t            in_item_q;
  logic             out_valid_q;
  result_t          out_res_q;
  result_t          res;
  logic             fire;
  logic [PresW-1:0] low_limit, high_limit;

  assign fire          = in_valid_q && (!out_valid_q || out_chan.ready);
  assign in_chan.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_q <= in_chan.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan.ready && in_chan.valid) begin
      in_item_q.action         <= in_chan.action;
      in_item_q.inject_phase   <= in_chan.inject_phase;
      in_item_q.dissolve_phase <= in_chan.dissolve_phase;
      in_item_q.pressure       <= in_chan.pressure;
    end
  end

  brs_cfg u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .we_i         (cfg_we_i),
    .idx_i        (cfg_idx_i),
    .data_i       (cfg_data_i),
    .low_limit_o  (low_limit),
    .high_limit_o (high_limit)
  );

  brs_fsm u_fsm (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (fire),
    .item_i       (in_item_q),
    .low_limit_i  (low_limit),
    .high_limit_i (high_limit),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) out_res_q <= res;
  end

  assign out_chan.valid         = out_valid_q;
  assign out_chan.proc_state    = out_res_q.proc_state;
  assign out_chan.recipe_step   = out_res_q.recipe_step;
  assign out_chan.phase_request = out_res_q.phase_request;
  assign out_chan.inject_amount = out_res_q.inject_amount;
  assign out_chan.unit_command  = out_res_q.unit_command;

endmodule

`default_nettype wire

@@ sv/brs_cfg.sv @@
// Pressure limit registers written through the plain configuration port.
// Depends on brs_pkg.
`default_nettype none

module brs_cfg
  import brs_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               we_i,
  input  wire logic [CfgIdxW-1:0] idx_i,
  input  wire logic [PresW-1:0]   data_i,
  output logic      [PresW-1:0]   low_limit_o,
  output logic      [PresW-1:0]   high_limit_o
);

  logic [PresW-1:0] low_q, high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= LowLimitRst;
      high_q <= HighLimitRst;
    end else if (we_i) begin
      case (cfg_idx_e'(idx_i))
        CFG_LOW_LIMIT:  low_q  <= data_i;
        CFG_HIGH_LIMIT: high_q <= data_i;
        default: ;
      endcase
    end
  end

  assign low_limit_o  = low_q;
  assign high_limit_o = high_q;

endmodule

`default_nettype wire

@@ sv/brs_fsm.sv @@
// Recipe state machine: procedure state and step registers, next-state
// and per-item output logic. Depends on brs_pkg.
`default_nettype none

module brs_fsm
  import brs_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire item_t            item_i,
  input  wire logic [PresW-1:0] low_limit_i,
  input  wire logic [PresW-1:0] high_limit_i,
  output result_t               res_o
);

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             below_low, above_high;
  logic             inj_done, dis_done;
  logic [1:0]       req;
  logic [1:0]       amt;
  cmd_e             cmd;

  assign below_low  = item_i.pressure < low_limit_i;
  assign above_high = item_i.pressure > high_limit_i;
  assign inj_done   = item_i.inject_phase == PH_COMPLETE;
  assign dis_done   = item_i.dissolve_phase == PH_COMPLETE;

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (action_e'(item_i.action))
      ACT_TICK: begin
        case (state_q)
          ST_EXEC: begin
            if (step_q[0]) begin
              if (inj_done) step_d = step_q + 3'd1;
            end else if (dis_done) begin
              if (below_low) begin
                step_d = (step_q == StepLast) ? StepLoop : step_q + 3'd1;
              end else if (above_high) begin
                state_d = ST_STOPPING;
              end else begin
                state_d = ST_COMPLETE;
              end
            end
          end
          ST_STOPPING: begin
            if (phase_settled(item_i.inject_phase) &&
                phase_settled(item_i.dissolve_phase)) state_d = ST_STOPPED;
          end
          ST_HOLDING: begin
            if ((phase_settled(item_i.inject_phase) ||
                 item_i.inject_phase == PH_HELD) &&
                (phase_settled(item_i.dissolve_phase) ||
                 item_i.dissolve_phase == PH_HELD)) state_d = ST_HELD;
          end
          ST_RESUMING: begin
            if ((phase_settled(item_i.inject_phase) ||
                 item_i.inject_phase == PH_EXEC) &&
                (phase_settled(item_i.dissolve_phase) ||
                 item_i.dissolve_phase == PH_EXEC)) state_d = ST_EXEC;
          end
          ST_RESETTING: begin
            if (item_i.inject_phase == PH_IDLE &&
                item_i.dissolve_phase == PH_IDLE) state_d = ST_IDLE;
          end
          default: ;
        endcase
      end
      ACT_START: begin
        if (state_q == ST_IDLE) state_d = ST_EXEC;
      end
      ACT_HOLD: begin
        if (state_q == ST_EXEC) state_d = ST_HOLDING;
      end
      ACT_STOP: begin
        if (state_q == ST_EXEC || state_q == ST_HELD ||
            state_q == ST_HOLDING || state_q == ST_RESUMING) state_d = ST_STOPPING;
      end
      ACT_RESUME: begin
        if (state_q == ST_HELD) state_d = ST_RESUMING;
      end
      ACT_RESET: begin
        if (state_q == ST_COMPLETE || state_q == ST_STOPPED) begin
          state_d = ST_RESETTING;
          step_d  = StepFirst;
        end
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    req = REQ_NONE;
    amt = 2'd0;
    cmd = CMD_NONE;
    case (action_e'(item_i.action))
      ACT_TICK: begin
        if (state_q == ST_EXEC) begin
          if (step_q[0]) begin
            req = REQ_INJECT;
            case (step_q)
              3'd1:    amt = 2'd3;
              3'd3:    amt = 2'd2;
              default: amt = 2'd1;
            endcase
          end else begin
            req = REQ_DISSOLVE;
            if (dis_done && !below_low && above_high) cmd = CMD_STOP;
          end
        end
      end
      ACT_HOLD: begin
        if (state_q == ST_EXEC) cmd = CMD_HOLD;
      end
      ACT_STOP: begin
        if (state_q == ST_EXEC || state_q == ST_HELD ||
            state_q == ST_HOLDING || state_q == ST_RESUMING) cmd = CMD_STOP;
      end
      ACT_RESUME: begin
        if (state_q == ST_HELD) cmd = CMD_RESUME;
      end
      ACT_RESET: begin
        if (state_q == ST_COMPLETE || state_q == ST_STOPPED) cmd = CMD_RESET;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= StepFirst;
    end else if (en_i) begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  assign res_o.proc_state    = state_d;
  assign res_o.recipe_step   = step_d;
  assign res_o.phase_request = req;
  assign res_o.inject_amount = amt;
  assign res_o.unit_command  = cmd;

  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q >= StepFirst && step_q <= StepLast)
    else $error("recipe step out of range");

  a_amount_inject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req == REQ_INJECT) == (amt != 2'd0))
    else $error("inject amount without inject request");

  a_stop_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && state_d == ST_STOPPING && state_q != ST_STOPPING |-> cmd == CMD_STOP)
    else $error("entered stopping without stop command");

  a_reset_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && cmd == CMD_RESET |=> step_q == StepFirst && state_q == ST_RESETTING)
    else $error("reset command did not rewind recipe");

  a_hold_only_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && cmd == CMD_HOLD |=> state_q == ST_HOLDING && $past(state_q) == ST_EXEC)
    else $error("hold issued outside executing");

endmodule

`default_nettype wire

@@ verif/batch_recipe_sequencer_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the batch recipe sequencer top level: directed
// table then state-aware random commands and ticks, checked against a predictor.
// Depends on brs_pkg, brs_in_if, brs_out_if and batch_recipe_sequencer_top.

module batch_recipe_sequencer_top_tb;
  import brs_pkg::*;

  localparam int          PRES_MAX     = (1 << PresW) - 1;
  localparam int          HOLD_CYCLES  = 200;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          PHASES       = 5;
  localparam int          PHASE_ITEMS  = 300;
  localparam logic [2:0]  ACT_UNUSED   = 3'd7;
  localparam logic [2:0]  PH_UNUSED    = 3'd7;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [PresW-1:0]   cfg_data_i;

  brs_in_if  in_chan ();
  brs_out_if out_chan ();

  batch_recipe_sequencer_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan    (in_chan),
    .out_chan   (out_chan),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  state_e           recipe_st;
  logic [StepW-1:0] recipe_stp;
  logic [PresW-1:0] lo_lim;
  logic [PresW-1:0] hi_lim;
  result_t          recipe_status_q[$];
  stim_row_t        dir_rows[$];

  int  mismatches;
  int  results_seen;
  int  src_idle_pct;
  int  snk_stall_pct;
  bit  hold_req;
  int  hold_left;
  int  quiet_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic phase_at_rest(logic [2:0] p);
    return p inside {PH_IDLE, PH_STOPPED, PH_COMPLETE};
  endfunction

  function automatic result_t predict_recipe(item_t it);
    result_t r;
    state_e  nxt;
    r   = '0;
    nxt = recipe_st;
    case (it.action)
      ACT_TICK: begin
        case (recipe_st)
          ST_EXEC: begin
            if (recipe_stp[0]) begin
              r.phase_request = REQ_INJECT;
              r.inject_amount = (recipe_stp == 3'd1) ? 2'd3 : (recipe_stp == 3'd3) ? 2'd2 : 2'd1;
              if (it.inject_phase == PH_COMPLETE) recipe_stp = recipe_stp + 3'd1;
            end else begin
              r.phase_request = REQ_DISSOLVE;
              if (it.dissolve_phase == PH_COMPLETE) begin
                if (it.pressure < lo_lim) begin
                  recipe_stp = (recipe_stp >= StepLast) ? StepLoop : recipe_stp + 3'd1;
                end else if (it.pressure > hi_lim) begin
                  nxt            = ST_STOPPING;
                  r.unit_command = CMD_STOP;
                end else begin
                  nxt = ST_COMPLETE;
                end
              end
            end
          end
          ST_STOPPING: begin
            if (phase_at_rest(it.inject_phase) && phase_at_rest(it.dissolve_phase))
              nxt = ST_STOPPED;
          end
          ST_HOLDING: begin
            if ((phase_at_rest(it.inject_phase) || it.inject_phase == PH_HELD) &&
                (phase_at_rest(it.dissolve_phase) || it.dissolve_phase == PH_HELD))
              nxt = ST_HELD;
          end
          ST_RESUMING: begin
            if ((phase_at_rest(it.inject_phase) || it.inject_phase == PH_EXEC) &&
                (phase_at_rest(it.dissolve_phase) || it.dissolve_phase == PH_EXEC))
              nxt = ST_EXEC;
          end
          ST_RESETTING: begin
            if (it.inject_phase == PH_IDLE && it.dissolve_phase == PH_IDLE) nxt = ST_IDLE;
          end
          default: ;
        endcase
      end
      ACT_START: begin
        if (recipe_st == ST_IDLE) nxt = ST_EXEC;
      end
      ACT_HOLD: begin
        if (recipe_st == ST_EXEC) begin
          nxt            = ST_HOLDING;
          r.unit_command = CMD_HOLD;
        end
      end
      ACT_STOP: begin
        if (recipe_st inside {ST_EXEC, ST_HELD, ST_HOLDING, ST_RESUMING}) begin
          nxt            = ST_STOPPING;
          r.unit_command = CMD_STOP;
        end
      end
      ACT_RESUME: begin
        if (recipe_st == ST_HELD) begin
          nxt            = ST_RESUMING;
          r.unit_command = CMD_RESUME;
        end
      end
      ACT_RESET: begin
        if (recipe_st == ST_COMPLETE || recipe_st == ST_STOPPED) begin
          recipe_stp     = StepFirst;
          nxt            = ST_RESETTING;
          r.unit_command = CMD_RESET;
        end
      end
      default: ;
    endcase
    recipe_st      = nxt;
    r.proc_state   = nxt;
    r.recipe_step  = recipe_stp;
    return r;
  endfunction

  function automatic logic [PresW-1:0] near_limit(logic [PresW-1:0] lim);
    int v;
    v = int'(lim) + int'($urandom_range(4)) - 2;
    if (v < 0) v = 0;
    if (v > PRES_MAX) v = PRES_MAX;
    return PresW'(v);
  endfunction

  function automatic logic [PresW-1:0] pick_pressure();
    case ($urandom_range(5))
      0:       return '0;
      1:       return PresW'(PRES_MAX);
      2, 3:    return near_limit(lo_lim);
      4:       return near_limit(hi_lim);
      default: return PresW'($urandom_range(PRES_MAX));
    endcase
  endfunction

  function automatic logic [2:0] pick_phase(logic [2:0] extra);
    case ($urandom_range(4))
      0:       return PH_IDLE;
      1:       return PH_STOPPED;
      2:       return PH_COMPLETE;
      3:       return extra;
      default: return 3'($urandom_range(7));
    endcase
  endfunction

  function automatic item_t next_random_item();
    item_t       it;
    int unsigned roll;
    it.action         = ACT_TICK;
    it.inject_phase   = 3'($urandom_range(7));
    it.dissolve_phase = 3'($urandom_range(7));
    it.pressure       = pick_pressure();
    roll              = $urandom_range(99);
    if (roll < 12) begin
      it.action = 3'($urandom_range(7));
      return it;
    end
    case (recipe_st)
      ST_IDLE: if (roll < 70) it.action = ACT_START;
      ST_EXEC: begin
        if (roll < 17) it.action = ACT_HOLD;
        else if (roll < 21) it.action = ACT_STOP;
        else begin
          if ($urandom_range(99) < 70) it.inject_phase = PH_COMPLETE;
          if ($urandom_range(99) < 70) it.dissolve_phase = PH_COMPLETE;
        end
      end
      ST_HOLDING: begin
        if (roll < 22) it.action = ACT_STOP;
        else begin
          it.inject_phase   = pick_phase(PH_HELD);
          it.dissolve_phase = pick_phase(PH_HELD);
        end
      end
      ST_HELD: begin
        if (roll < 70) it.action = ACT_RESUME;
        else if (roll < 85) it.action = ACT_STOP;
      end
      ST_RESUMING: begin
        if (roll < 22) it.action = ACT_STOP;
        else begin
          it.inject_phase   = pick_phase(PH_EXEC);
          it.dissolve_phase = pick_phase(PH_EXEC);
        end
      end
      ST_STOPPING: begin
        it.inject_phase   = pick_phase(PH_COMPLETE);
        it.dissolve_phase = pick_phase(PH_COMPLETE);
      end
      ST_STOPPED, ST_COMPLETE: if (roll < 70) it.action = ACT_RESET;
      ST_RESETTING: begin
        if (roll < 80) begin
          it.inject_phase   = PH_IDLE;
          it.dissolve_phase = PH_IDLE;
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  function automatic stim_row_t row(logic [2:0] act, logic [2:0] inj, logic [2:0] dis,
                                    int pres, bit typed, result_t want);
    stim_row_t r;
    r.it.action         = act;
    r.it.inject_phase   = inj;
    r.it.dissolve_phase = dis;
    r.it.pressure       = PresW'(pres);
    r.typed             = typed;
    r.want              = want;
    return r;
  endfunction

  function automatic result_t res(state_e st, logic [StepW-1:0] stp, req_e req,
                                  logic [1:0] amt, cmd_e cmd);
    result_t r;
    r.proc_state    = st;
    r.recipe_step   = stp;
    r.phase_request = req;
    r.inject_amount = amt;
    r.unit_command  = cmd;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < 40)
      $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, results_seen);
    mismatches++;
  endtask

  task automatic send_item(item_t it, bit typed, result_t want);
    result_t pred;
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_chan.valid          <= 1'b1;
    in_chan.action         <= it.action;
    in_chan.inject_phase   <= it.inject_phase;
    in_chan.dissolve_phase <= it.dissolve_phase;
    in_chan.pressure       <= it.pressure;
    do @(posedge clk_i); while (!in_chan.ready);
    pred = predict_recipe(it);
    recipe_status_q.push_back(typed ? want : pred);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    while (recipe_status_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic set_limits(logic [PresW-1:0] lo, logic [PresW-1:0] hi);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_LOW_LIMIT;
    cfg_data_i <= lo;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HIGH_LIMIT;
    cfg_data_i <= hi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    lo_lim = lo;
    hi_lim = hi;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_chan.ready <= 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_chan.valid && out_chan.ready) begin
      if (recipe_status_q.size() == 0) begin
        report_mismatch("unexpected result", out_chan.proc_state, 0);
      end else begin
        want = recipe_status_q.pop_front();
        if (out_chan.proc_state !== want.proc_state)
          report_mismatch("proc_state", out_chan.proc_state, want.proc_state);
        if (out_chan.recipe_step !== want.recipe_step)
          report_mismatch("recipe_step", out_chan.recipe_step, want.recipe_step);
        if (out_chan.phase_request !== want.phase_request)
          report_mismatch("phase_request", out_chan.phase_request, want.phase_request);
        if (out_chan.inject_amount !== want.inject_amount)
          report_mismatch("inject_amount", out_chan.inject_amount, want.inject_amount);
        if (out_chan.unit_command !== want.unit_command)
          report_mismatch("unit_command", out_chan.unit_command, want.unit_command);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int lo_set  [PHASES];
    int hi_set  [PHASES];
    int src_set [PHASES];
    int snk_set [PHASES];
    mismatches    = 0;
    results_seen  = 0;
    quiet_cycles  = 0;
    hold_req      = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    recipe_st     = ST_IDLE;
    recipe_stp    = StepFirst;
    lo_lim        = LowLimitRst;
    hi_lim        = HighLimitRst;
    rst_ni                 <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= CFG_LOW_LIMIT;
    cfg_data_i             <= '0;
    in_chan.valid          <= 1'b0;
    in_chan.action         <= ACT_TICK;
    in_chan.inject_phase   <= PH_IDLE;
    in_chan.dissolve_phase <= PH_IDLE;
    in_chan.pressure       <= '0;

    dir_rows.push_back(row(ACT_TICK, PH_IDLE, PH_IDLE, 0, 1'b1,
                           res(ST_IDLE, StepFirst, REQ_NONE, 2'd0, CMD_NONE)));
    dir_rows.push_back(row(ACT_UNUSED, PH_UNUSED, PH_UNUSED, PRES_MAX, 1'b1,
                           res(ST_IDLE, StepFirst, REQ_NONE, 2'd0, CMD_NONE)));
    dir_rows.push_back(row(ACT_HOLD, PH_IDLE, PH_IDLE, 0, 1'b1,
                           res(ST_IDLE, StepFirst, REQ_NONE, 2'd0, CMD_NONE)));
    dir_rows.push_back(row(ACT_START, PH_IDLE, PH_IDLE, 0, 1'b1,
                           res(ST_EXEC, StepFirst, REQ_NONE, 2'd0, CMD_NONE)));
    dir_rows.push_back(row(ACT_TICK, PH_EXEC, PH_IDLE, 500, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_COMPLETE, PH_IDLE, 500, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_IDLE, PH_COMPLETE, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_COMPLETE, PH_IDLE, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_IDLE, PH_COMPLETE, 899, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_COMPLETE, PH_IDLE, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_IDLE, PH_COMPLETE, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_COMPLETE, PH_IDLE, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_HOLD, PH_EXEC, PH_EXEC, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_OTHER, PH_IDLE, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_UNUSED, PH_HELD, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_HELD, PH_IDLE, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_RESUME, PH_HELD, PH_HELD, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_EXEC, PH_EXEC, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_IDLE, PH_COMPLETE, PRES_MAX, 1'b1,
                           res(ST_STOPPING, StepLast, REQ_DISSOLVE, 2'd0, CMD_STOP)));
    dir_rows.push_back(row(ACT_TICK, PH_STOPPED, PH_COMPLETE, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_RESET, PH_STOPPED, PH_STOPPED, 0, 1'b1,
                           res(ST_RESETTING, StepFirst, REQ_NONE, 2'd0, CMD_RESET)));
    dir_rows.push_back(row(ACT_TICK, PH_IDLE, PH_IDLE, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_START, PH_IDLE, PH_IDLE, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_COMPLETE, PH_IDLE, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_IDLE, PH_COMPLETE, 1000, 1'b0, '0));
    dir_rows.push_back(row(ACT_START, PH_IDLE, PH_IDLE, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_RESET, PH_COMPLETE, PH_COMPLETE, 0, 1'b0, '0));
    dir_rows.push_back(row(ACT_TICK, PH_IDLE, PH_OTHER, 0, 1'b0, '0));

    lo_set[0] = LowLimitRst;  hi_set[0] = HighLimitRst; src_set[0] = 0;  snk_set[0] = 0;
    lo_set[1] = 0;            hi_set[1] = PRES_MAX;     src_set[1] = 55; snk_set[1] = 0;
    lo_set[2] = PRES_MAX;     hi_set[2] = 0;            src_set[2] = 0;  snk_set[2] = 55;
    lo_set[3] = $urandom_range(PRES_MAX);
    hi_set[3] = lo_set[3] + $urandom_range(PRES_MAX - lo_set[3]);
    src_set[3] = 30; snk_set[3] = 30;
    lo_set[4] = $urandom_range(PRES_MAX);
    hi_set[4] = $urandom_range(PRES_MAX);
    src_set[4] = 30; snk_set[4] = 30;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      set_limits(PresW'(lo_set[p]), PresW'(hi_set[p]));
      src_idle_pct  = src_set[p];
      snk_stall_pct = snk_set[p];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == 100) hold_req = 1'b1;
        if (p == 2 && n == 150) drain_results();
        send_item(next_random_item(), 1'b0, '0);
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

@@ batch_recipe_sequencer_top.f @@
sv/brs_pkg.sv
sv/brs_in_if.sv
sv/brs_out_if.sv
sv/brs_cfg.sv
sv/brs_fsm.sv
sv/batch_recipe_sequencer_top.sv
verif/batch_recipe_sequencer_top_tb.sv
